// ----- sv/qf2u_pkg.sv -----
// ---------------------------------------------------------------------------
// qf2u_pkg
// Shared types and constants for the binary128 to uint32 converter.
// ---------------------------------------------------------------------------
`default_nettype none
package qf2u_pkg;
    localparam logic [14:0] EXP_BIAS = 15'h3fff;
    localparam logic [14:0] EXP_TOP  = 15'h401e;
    localparam logic [31:0] SAT_POS  = 32'h7fffffff;
    localparam logic [31:0] SAT_NEG  = 32'h80000000;
    localparam logic [1:0]  REG_INEXACT_TE = 2'd0;
    localparam logic [1:0]  REG_INVALID_TE = 2'd1;

    typedef struct packed {
        logic        sign;
        logic [14:0] exponent;
        logic [47:0] frac_high;
        logic [63:0] frac_low;
    } qf2u_in_t;

    typedef struct packed {
        logic inexact_te;
        logic invalid_te;
    } qf2u_cfg_t;

    typedef struct packed {
        logic inexact_trap;
        logic invalid_trap;
        logic inexact_flag;
        logic invalid_flag;
    } qf2u_flags_t;
endpackage
`default_nettype wire

// ----- sv/qf2u_convert.sv -----
// ---------------------------------------------------------------------------
// qf2u_convert
// Combinational truncating conversion of one operand with flag routing.
// ---------------------------------------------------------------------------
`default_nettype none
module qf2u_convert import qf2u_pkg::*; (
    input  wire qf2u_in_t    op,
    input  wire qf2u_cfg_t   cfg,
    output logic [31:0]      value,
    output qf2u_flags_t      flags
);
    logic [31:0] mant;
    logic        tail;
    logic [4:0]  sh;
    logic [31:0] shifted;
    logic [31:0] lost_mask;
    logic        inexact;
    logic        invalid;
    logic [14:0] ediff;

    assign mant      = {1'b1, op.frac_high[47:17]};
    assign tail      = (|op.frac_high[16:0]) | (|op.frac_low);
    assign ediff     = op.exponent - EXP_BIAS;
    assign sh        = 5'd31 - ediff[4:0];
    assign shifted   = mant >> sh;
    assign lost_mask = (32'd1 << sh) - 32'd1;

    always_comb begin
        value   = '0;
        inexact = 1'b0;
        invalid = 1'b0;
        if (op.exponent >= EXP_TOP) begin
            if (op.exponent == EXP_TOP && !op.sign) begin
                value   = mant;
                inexact = tail;
            end else if (op.exponent == EXP_TOP && op.frac_high[47:17] == '0) begin
                value   = SAT_NEG;
                inexact = tail;
            end else begin
                value   = op.sign ? SAT_NEG : SAT_POS;
                invalid = 1'b1;
            end
        end else if (op.exponent < EXP_BIAS) begin
            inexact = (|op.exponent) | (|op.frac_high) | (|op.frac_low);
        end else begin
            value   = op.sign ? (32'd0 - shifted) : shifted;
            inexact = (|(mant & lost_mask)) | tail;
        end
        flags.invalid_flag = invalid & ~cfg.invalid_te;
        flags.inexact_flag = inexact & ~cfg.inexact_te;
        flags.invalid_trap = invalid & cfg.invalid_te;
        flags.inexact_trap = inexact & cfg.inexact_te;
    end
endmodule
`default_nettype wire

// ----- sv/quad_float_to_uint32_core.sv -----
// ---------------------------------------------------------------------------
// quad_float_to_uint32_core
// Binary128 to 32-bit pattern conversion, truncating toward zero.
// ---------------------------------------------------------------------------
// One operand is taken per clock unless the output is stalled. An accepted
// operand lands in the input register, the conversion (a 32-bit right
// shift, a negate and a few exponent compares) runs combinationally on it,
// and the result is captured in the output register. Both registers move
// together when the output is free or taken, so s_tready follows the
// output side. Trap enables are written over APB at 0x0 (inexact) and 0x4
// (invalid), by the user only while the block is idle; it is not enforced.
// ---------------------------------------------------------------------------
`default_nettype none
module quad_float_to_uint32_core import qf2u_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // sign[0], exponent[15:1], frac_high[63:16], frac_low[127:64]
    input  wire [127:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // value[31:0], invalid_flag[32], inexact_flag[33], invalid_trap[34],
    // inexact_trap[35], zeros above
    output logic [39:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    qf2u_in_t    in_reg;
    logic        in_vld_reg;
    logic [35:0] out_reg;
    logic        out_vld_reg;
    qf2u_cfg_t   cfg_reg;
    logic [31:0] conv_value;
    qf2u_flags_t conv_flags;
    logic        advance;
    logic        cfg_wr;

    // Pipeline moves whenever the output slot is empty or being taken.
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_reg};
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    qf2u_convert u_conv (
        .op    (in_reg),
        .cfg   (cfg_reg),
        .value (conv_value),
        .flags (conv_flags)
    );

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_INEXACT_TE[0]: prdata = {31'd0, cfg_reg.inexact_te};
            REG_INVALID_TE[0]: prdata = {31'd0, cfg_reg.invalid_te};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cfg_reg     <= '0;
        end else begin
            if (advance) begin
                in_vld_reg  <= s_tvalid;
                out_vld_reg <= in_vld_reg;
            end
            if (cfg_wr && paddr[1:0] == 2'd0) begin
                if (paddr[2] == REG_INEXACT_TE[0]) cfg_reg.inexact_te <= pwdata[0];
                if (paddr[2] == REG_INVALID_TE[0]) cfg_reg.invalid_te <= pwdata[0];
            end
        end
    end

    // Payload: hold while stalled.
    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg  <= qf2u_in_t'({s_tdata[0], s_tdata[15:1], s_tdata[63:16],
                                   s_tdata[127:64]});
            out_reg <= {conv_flags.inexact_trap, conv_flags.invalid_trap,
                        conv_flags.inexact_flag, conv_flags.invalid_flag, conv_value};
        end
    end

`ifndef SYNTHESIS
    a_trap_flag_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[34]))
        else $error("invalid both flagged and trapped");
    a_invalid_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[32] || m_tdata[34])) |->
            (m_tdata[31:0] == SAT_POS || m_tdata[31:0] == SAT_NEG))
        else $error("invalid result not saturated");
    a_invalid_not_inexact: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[32] || m_tdata[34])) |-> !(m_tdata[33] || m_tdata[35]))
        else $error("invalid with inexact");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");
`endif
endmodule
`default_nettype wire
